### rtl/sccbm_pkg.sv
// ----------------------------------------------------------------------------
// sccbm_pkg
// Types and constants for the cartridge bank mapper with the sound register
// window.
// ----------------------------------------------------------------------------
package sccbm_pkg;

  localparam int REGIONS      = 4;
  localparam int MAX_SEGMENTS = 128;
  localparam int REGION_W     = $clog2(REGIONS);
  localparam int BANK_W       = 6;
  localparam int SEG_CNT_W    = 8;
  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int MEM_ADDR_W   = 20;
  localparam int OFFSET_W     = 13;
  localparam int TARGET_W     = 2;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [TARGET_W-1:0] TARGET_NONE   = 2'd0;
  localparam logic [TARGET_W-1:0] TARGET_SRAM   = 2'd1;
  localparam logic [TARGET_W-1:0] TARGET_SCC    = 2'd2;
  localparam logic [TARGET_W-1:0] TARGET_MAPPER = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_SRAM_SEGMENTS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCC_ENABLE    = 1'd1;

  localparam logic [SEG_CNT_W-1:0] SEG_CNT_RESET = 8'd128;
  localparam logic [SEG_CNT_W-1:0] SEG_CNT_MAX   = 8'(MAX_SEGMENTS);
  localparam logic [BANK_W-1:0]    SCC_BANK      = 6'h3f;
  localparam logic [REGION_W-1:0]  SCC_REGION    = 2'd2;
  localparam logic [REGION_W-1:0]  UPPER_REGION  = 2'd0;

  localparam logic [4:0]  AREA_SCC      = 5'h13;
  localparam logic [4:0]  AREA_BANK0    = 5'h0a;
  localparam logic [4:0]  AREA_BANK1    = 5'h0e;
  localparam logic [4:0]  AREA_BANK2    = 5'h12;
  localparam logic [4:0]  AREA_BANK3    = 5'h16;
  localparam logic [10:0] FOLD_MASK_ROW = 11'h4c4;
  localparam logic [10:0] FOLD_FIX_ROW  = 11'h4c7;
  localparam logic [OFFSET_W-1:0] FOLD_MASK  = 13'h1fef;
  localparam logic [OFFSET_W-1:0] FOLD_FIXED = 13'h18e0;

  typedef logic [REGIONS-1:0][BANK_W-1:0] bank_array_t;

  localparam bank_array_t BANK_RESET = {6'd3, 6'd2, 6'd1, 6'd0};

  typedef struct packed {
    logic                bank_we;
    logic [REGION_W-1:0] bank_idx;
    logic [BANK_W-1:0]   bank_val;
    logic                flag_we;
    logic                upper;
    logic                sram_wm;
  } state_update_t;

  typedef struct packed {
    logic [TARGET_W-1:0]   target;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic [OFFSET_W-1:0]   scc_offset;
    logic                  is_write;
    logic [DATA_W-1:0]     write_byte;
  } result_t;

endpackage

### rtl/scc_sram_bank_mapper_top.sv
// ----------------------------------------------------------------------------
// scc_sram_bank_mapper_top
// Cartridge bank mapper: decodes one bus access per cycle, when not stalled,
// into an SRAM, sound register or mapper register transfer, or none.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   input    | in_valid / in_stall      | req_type, bus_addr, bus_wdata
//   output   | out_valid / out_stall    | target, mem_addr, scc_offset,
//            |                          | is_write, write_byte
//   config   | cfg_write                | cfg_index, cfg_data
//
// Each access passes through one input register, then decode and bank
// update into the result register. A new access is taken every cycle
// while in_stall is low. Bank and flag state change when the access
// leaves the input register, so accesses see updates strictly in order.
// Reset is synchronous and restores banks 0..3, clears the flags and sets
// 128 segments with the sound window enabled. in_stall rises only when both
// registers are full and the output is stalled.
// ----------------------------------------------------------------------------
module scc_sram_bank_mapper_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sccbm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sccbm_pkg::SEG_CNT_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [sccbm_pkg::ADDR_W-1:0]      bus_addr,
  input  logic [sccbm_pkg::DATA_W-1:0]      bus_wdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sccbm_pkg::TARGET_W-1:0]    target,
  output logic [sccbm_pkg::MEM_ADDR_W-1:0]  mem_addr,
  output logic [sccbm_pkg::OFFSET_W-1:0]    scc_offset,
  output logic                              is_write,
  output logic [sccbm_pkg::DATA_W-1:0]      write_byte
);
  import sccbm_pkg::*;

  logic [SEG_CNT_W-1:0] sram_segments;
  logic                 scc_enable;
  logic                 s1_valid;
  logic                 s1_req_type;
  logic [ADDR_W-1:0]    s1_addr;
  logic [DATA_W-1:0]    s1_data;
  logic                 out_free;
  logic                 s1_advance;
  bank_array_t          banks;
  logic                 upper;
  logic                 sram_wm;
  result_t              res;
  state_update_t        upd;
  state_update_t        upd_gated;

  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  assign in_stall   = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sram_segments <= SEG_CNT_RESET;
      scc_enable    <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SRAM_SEGMENTS: sram_segments <= cfg_data;
        CFG_SCC_ENABLE:    scc_enable    <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_type <= req_type;
      s1_addr     <= bus_addr;
      s1_data     <= bus_wdata;
    end
  end

  sccbm_decode u_decode (
    .req_type      (s1_req_type),
    .bus_addr      (s1_addr),
    .bus_wdata     (s1_data),
    .banks         (banks),
    .upper         (upper),
    .sram_wm       (sram_wm),
    .sram_segments (sram_segments),
    .scc_enable    (scc_enable),
    .res           (res),
    .upd           (upd)
  );

  always_comb begin
    upd_gated         = upd;
    upd_gated.bank_we = upd.bank_we && s1_advance;
    upd_gated.flag_we = upd.flag_we && s1_advance;
  end

  sccbm_bank_regs u_bank_regs (
    .clk     (clk),
    .rst     (rst),
    .upd     (upd_gated),
    .banks   (banks),
    .upper   (upper),
    .sram_wm (sram_wm)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      target     <= res.target;
      mem_addr   <= res.mem_addr;
      scc_offset <= res.scc_offset;
      is_write   <= res.is_write;
      write_byte <= res.write_byte;
    end
  end

endmodule

### rtl/sccbm_bank_regs.sv
// ----------------------------------------------------------------------------
// sccbm_bank_regs
// Bank number registers and the upper-half and SRAM-write flags.
// ----------------------------------------------------------------------------
module sccbm_bank_regs (
  input  logic                    clk,
  input  logic                    rst,
  input  sccbm_pkg::state_update_t upd,
  output sccbm_pkg::bank_array_t  banks,
  output logic                    upper,
  output logic                    sram_wm
);
  import sccbm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      banks   <= BANK_RESET;
      upper   <= 1'b0;
      sram_wm <= 1'b0;
    end else begin
      if (upd.bank_we) begin
        banks[upd.bank_idx] <= upd.bank_val;
      end
      if (upd.flag_we) begin
        upper   <= upd.upper;
        sram_wm <= upd.sram_wm;
      end
    end
  end

endmodule

### rtl/sccbm_decode.sv
// ----------------------------------------------------------------------------
// sccbm_decode
// Access decode: target, SRAM address, sound register offset and the
// mapper state update for one bus access.
// ----------------------------------------------------------------------------
module sccbm_decode (
  input  logic                          req_type,
  input  logic [sccbm_pkg::ADDR_W-1:0]  bus_addr,
  input  logic [sccbm_pkg::DATA_W-1:0]  bus_wdata,
  input  sccbm_pkg::bank_array_t        banks,
  input  logic                          upper,
  input  logic                          sram_wm,
  input  logic [sccbm_pkg::SEG_CNT_W-1:0] sram_segments,
  input  logic                          scc_enable,
  output sccbm_pkg::result_t            res,
  output sccbm_pkg::state_update_t      upd
);
  import sccbm_pkg::*;

  logic [REGION_W-1:0]  region;
  logic [BANK_W-1:0]    seg;
  logic [SEG_CNT_W-1:0] count;
  logic                 in_range;
  logic                 is_scc_map;
  logic                 seg_present;
  logic                 upper_add;
  logic [MEM_ADDR_W-1:0] sram_addr;
  logic [4:0]           area;
  logic                 flag_hit;
  logic                 bank_hit;
  logic [OFFSET_W-1:0]  low_off;
  logic [OFFSET_W-1:0]  fold_off;

  assign region      = {~bus_addr[14], bus_addr[13]};
  assign seg         = banks[region];
  assign count       = (sram_segments > SEG_CNT_MAX) ? SEG_CNT_MAX : sram_segments;
  assign in_range    = (bus_addr[15:14] == 2'b01) || (bus_addr[15:14] == 2'b10);
  assign is_scc_map  = (region == SCC_REGION) && (seg == SCC_BANK);
  assign seg_present = {2'b00, seg} < count;
  assign upper_add   = (region == UPPER_REGION) && upper && (count == SEG_CNT_MAX);
  assign low_off     = bus_addr[OFFSET_W-1:0];
  assign sram_addr   = {upper_add, seg, low_off};
  assign area        = bus_addr[15:11];
  assign flag_hit    = &bus_addr[14:1];
  assign bank_hit    = (area == AREA_BANK0) || (area == AREA_BANK1) ||
                       (area == AREA_BANK2) || (area == AREA_BANK3);

  always_comb begin
    priority if (bus_addr[15:5] == FOLD_MASK_ROW) begin
      fold_off = low_off & FOLD_MASK;
    end else if (bus_addr[15:5] == FOLD_FIX_ROW) begin
      fold_off = FOLD_FIXED;
    end else begin
      fold_off = low_off;
    end
  end

  always_comb begin
    res          = '0;
    upd          = '0;
    upd.bank_idx = region;
    upd.bank_val = bus_wdata[BANK_W-1:0];
    upd.upper    = bus_wdata[6];
    upd.sram_wm  = bus_wdata[4];
    if (in_range) begin
      priority if (!req_type) begin
        if (is_scc_map) begin
          res.target     = TARGET_SCC;
          res.scc_offset = low_off;
        end else if (seg_present) begin
          res.target   = TARGET_SRAM;
          res.mem_addr = sram_addr;
        end
      end else if (flag_hit) begin
        upd.flag_we    = 1'b1;
        res.target     = TARGET_MAPPER;
        res.is_write   = 1'b1;
        res.write_byte = bus_wdata;
      end else if (sram_wm && !bus_addr[15]) begin
        if (seg_present) begin
          res.target     = TARGET_SRAM;
          res.mem_addr   = sram_addr;
          res.is_write   = 1'b1;
          res.write_byte = bus_wdata;
        end
      end else if (bank_hit) begin
        upd.bank_we    = 1'b1;
        res.target     = TARGET_MAPPER;
        res.is_write   = 1'b1;
        res.write_byte = bus_wdata;
      end else if (area == AREA_SCC) begin
        if ((banks[SCC_REGION] == SCC_BANK) && scc_enable) begin
          res.target     = TARGET_SCC;
          res.scc_offset = fold_off;
          res.is_write   = 1'b1;
          res.write_byte = bus_wdata;
        end
      end else begin
        res.target = TARGET_NONE;
      end
    end
  end

endmodule

### verif/scc_sram_bank_mapper_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scc_sram_bank_mapper_top_test
// Self-checking bench for the cartridge bank mapper. A directed table and
// constrained-by-hand random bus accesses run through several segment-count
// and sound-window settings. Expected transfers come from the typed table
// rows or a local predictor, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module scc_sram_bank_mapper_top_test;
  import sccbm_pkg::*;

  localparam int DIRECTED_ROWS  = 25;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 221;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } access_t;

  typedef struct packed {
    access_t acc;
    logic    typed;
    result_t res;
  } directed_row_t;

  localparam result_t NO_RESULT = '0;

  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{1'b0, 16'h4000, 8'h00}, 1'b1, '{TARGET_SRAM, 20'h00000, 13'h0, 1'b0, 8'h00}},
    '{'{1'b0, 16'hbfff, 8'h00}, 1'b1, '{TARGET_SRAM, 20'h07fff, 13'h0, 1'b0, 8'h00}},
    '{'{1'b0, 16'h3fff, 8'hff}, 1'b1, NO_RESULT},
    '{'{1'b1, 16'h0000, 8'hff}, 1'b1, NO_RESULT},
    '{'{1'b1, 16'hffff, 8'hff}, 1'b1, NO_RESULT},
    '{'{1'b1, 16'h5000, 8'hff}, 1'b1, '{TARGET_MAPPER, 20'h0, 13'h0, 1'b1, 8'hff}},
    '{'{1'b0, 16'h4123, 8'h00}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h7ffe, 8'h50}, 1'b1, '{TARGET_MAPPER, 20'h0, 13'h0, 1'b1, 8'h50}},
    '{'{1'b0, 16'h5fff, 8'h00}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h6000, 8'ha5}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h7000, 8'h12}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h7fff, 8'h00}, 1'b1, '{TARGET_MAPPER, 20'h0, 13'h0, 1'b1, 8'h00}},
    '{'{1'b1, 16'h9000, 8'h3f}, 1'b1, '{TARGET_MAPPER, 20'h0, 13'h0, 1'b1, 8'h3f}},
    '{'{1'b0, 16'h8005, 8'h00}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h9880, 8'h11}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h989f, 8'h22}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h98e0, 8'h33}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h98ff, 8'h44}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h9fff, 8'h55}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h9800, 8'h66}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h8000, 8'h77}, 1'b1, NO_RESULT},
    '{'{1'b1, 16'hb7ff, 8'h40}, 1'b1, '{TARGET_MAPPER, 20'h0, 13'h0, 1'b1, 8'h40}},
    '{'{1'b1, 16'hb800, 8'h01}, 1'b1, NO_RESULT},
    '{'{1'b0, 16'ha000, 8'h00}, 1'b0, NO_RESULT},
    '{'{1'b1, 16'h57ff, 8'h80}, 1'b1, '{TARGET_MAPPER, 20'h0, 13'h0, 1'b1, 8'h80}}
  };

  localparam logic [SEG_CNT_W-1:0] PHASE_SEGMENTS [PHASES] = '{8'd128, 8'd0, 8'd64, 8'd1,
                                                               8'd127, 8'd128};
  localparam logic PHASE_SCC_ON [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = CFG_SRAM_SEGMENTS;
  logic [SEG_CNT_W-1:0]   cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic                   req_type   = 1'b0;
  logic [ADDR_W-1:0]      bus_addr   = '0;
  logic [DATA_W-1:0]      bus_wdata  = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [TARGET_W-1:0]    target;
  logic [MEM_ADDR_W-1:0]  mem_addr;
  logic [OFFSET_W-1:0]    scc_offset;
  logic                   is_write;
  logic [DATA_W-1:0]      write_byte;

  // predictor state
  bank_array_t          bank_sel     = BANK_RESET;
  logic                 upper_sel    = 1'b0;
  logic                 sram_wr_mode = 1'b0;
  logic [SEG_CNT_W-1:0] seg_limit    = SEG_CNT_RESET;
  logic                 scc_on       = 1'b1;

  result_t pending_results [$];
  int      fail_cnt       = 0;
  int      idle_cycles    = 0;
  int      src_gap_pct    = 0;
  int      sink_stall_pct = 0;
  bit      hold_req       = 1'b0;

  scc_sram_bank_mapper_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .bus_addr   (bus_addr),
    .bus_wdata  (bus_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .target     (target),
    .mem_addr   (mem_addr),
    .scc_offset (scc_offset),
    .is_write   (is_write),
    .write_byte (write_byte)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [TARGET_W-1:0] region_lookup(input logic [REGION_W-1:0] region,
                                                        output logic [MEM_ADDR_W-1:0] base);
    logic [SEG_CNT_W-1:0] cnt;
    cnt  = (seg_limit > SEG_CNT_MAX) ? SEG_CNT_MAX : seg_limit;
    base = '0;
    if (region == SCC_REGION && bank_sel[region] == SCC_BANK) return TARGET_SCC;
    if ({2'b00, bank_sel[region]} >= cnt) return TARGET_NONE;
    base = MEM_ADDR_W'(bank_sel[region]) << 13;
    if (region == UPPER_REGION && upper_sel && cnt == SEG_CNT_MAX) begin
      base = base + 20'h80000;
    end
    return TARGET_SRAM;
  endfunction

  function automatic result_t decode_access(input logic wr, input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] data);
    result_t                res;
    logic [REGION_W-1:0]    region;
    logic [4:0]             area;
    logic [MEM_ADDR_W-1:0]  base;
    logic [TARGET_W-1:0]    hit;
    res    = '0;
    region = REGION_W'(addr[15:13] - 3'd2);
    area   = addr[15:11];
    if (addr >= 16'h4000 && addr <= 16'hbfff) begin
      if (!wr) begin
        hit = region_lookup(region, base);
        res.target = hit;
        if (hit == TARGET_SRAM) begin
          res.mem_addr = base + MEM_ADDR_W'(addr[12:0]);
        end else if (hit == TARGET_SCC) begin
          res.scc_offset = addr[12:0];
        end
      end else if (addr[14:1] == 14'h3fff) begin
        upper_sel      = data[6];
        sram_wr_mode   = data[4];
        res.target     = TARGET_MAPPER;
        res.is_write   = 1'b1;
        res.write_byte = data;
      end else if (sram_wr_mode && !addr[15]) begin
        hit = region_lookup(region, base);
        if (hit == TARGET_SRAM) begin
          res.target     = TARGET_SRAM;
          res.mem_addr   = base + MEM_ADDR_W'(addr[12:0]);
          res.is_write   = 1'b1;
          res.write_byte = data;
        end
      end else if (area == AREA_BANK0 || area == AREA_BANK1 || area == AREA_BANK2 ||
                   area == AREA_BANK3) begin
        bank_sel[region] = data[BANK_W-1:0];
        res.target       = TARGET_MAPPER;
        res.is_write     = 1'b1;
        res.write_byte   = data;
      end else if (area == AREA_SCC) begin
        if (bank_sel[SCC_REGION] == SCC_BANK && scc_on) begin
          res.target     = TARGET_SCC;
          res.is_write   = 1'b1;
          res.write_byte = data;
          if (addr >= 16'h9880 && addr <= 16'h989f) begin
            res.scc_offset = addr[12:0] & FOLD_MASK;
          end else if (addr >= 16'h98e0 && addr <= 16'h98ff) begin
            res.scc_offset = FOLD_FIXED;
          end else begin
            res.scc_offset = addr[12:0];
          end
        end
      end
    end
    return res;
  endfunction

  function automatic access_t random_access();
    access_t    a;
    int         kind;
    logic [1:0] r;
    kind   = $urandom_range(99);
    a.wr   = 1'($urandom);
    a.data = 8'($urandom);
    a.addr = 16'($urandom_range(16'hbfff, 16'h4000));
    if (kind < 22) begin
      r      = 2'($urandom);
      a.wr   = 1'b1;
      a.addr = {3'(r + 2'd2), 2'b10, 11'($urandom)};
      case ($urandom_range(2))
        0: a.data[BANK_W-1:0] = SCC_BANK;
        1: a.data[BANK_W-1:0] = 6'($urandom_range(7));
        default: ;
      endcase
    end else if (kind < 30) begin
      a.wr   = 1'b1;
      a.addr = {15'h3fff, 1'($urandom)};
    end else if (kind < 50) begin
      a.wr = 1'b1;
      if ($urandom_range(1)) a.addr = {5'h13, 3'b000, 1'b1, 7'($urandom)};
      else a.addr = {5'h13, 11'($urandom)};
    end else if (kind < 78) begin
      a.wr = 1'b0;
    end else if (kind < 92) begin
      a.wr = 1'b1;
    end else begin
      a.addr = 16'($urandom);
    end
    return a;
  endfunction

  function automatic int field_diff(input string name, input logic [MEM_ADDR_W-1:0] want,
                                    input logic [MEM_ADDR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic issue_access(input access_t acc, input logic typed, input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= acc.wr;
    bus_addr  <= acc.addr;
    bus_wdata <= acc.data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = decode_access(acc.wr, acc.addr, acc.data);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input logic [SEG_CNT_W-1:0] segs, input logic en);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SRAM_SEGMENTS;
    cfg_data  <= segs;
    @(posedge clk);
    seg_limit  = segs;
    cfg_index <= CFG_SCC_ENABLE;
    cfg_data  <= {7'b0, en};
    @(posedge clk);
    scc_on     = en;
    cfg_write <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: target 'h%0h", target);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        fail_cnt += field_diff("target", MEM_ADDR_W'(want.target), MEM_ADDR_W'(target))
                  + field_diff("mem_addr", want.mem_addr, mem_addr)
                  + field_diff("scc_offset", MEM_ADDR_W'(want.scc_offset),
                               MEM_ADDR_W'(scc_offset))
                  + field_diff("is_write", MEM_ADDR_W'(want.is_write), MEM_ADDR_W'(is_write))
                  + field_diff("write_byte", MEM_ADDR_W'(want.write_byte),
                               MEM_ADDR_W'(write_byte));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** scc_sram_bank_mapper_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sent;
    src_gap_pct    = 7;
    sink_stall_pct = 79;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      issue_access(DIRECTED[i].acc, DIRECTED[i].typed, DIRECTED[i].res);
    end
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      src_gap_pct    = (phase < 2) ? 7 : (phase < 4) ? 79 : 0;
      sink_stall_pct = (phase < 2) ? 79 : (phase < 4) ? 7 : 0;
      load_config(PHASE_SEGMENTS[phase], PHASE_SCC_ON[phase]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // hold the output off while the sender keeps offering
        if (phase == 0 && sent == 40) hold_req = 1'b1;
        issue_access(random_access(), 1'b0, NO_RESULT);
        sent++;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("** scc_sram_bank_mapper_top: PASSED **");
    end else begin
      $display("** scc_sram_bank_mapper_top: FAILED **");
    end
    $finish;
  end

endmodule
